// File: design/assert_macros.svh
// assertion macros shared by the keypad door opener design
// no dependencies; include by bare file name where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define KDOC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property violated");

// expression must never be true outside reset
`define KDOC_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

// File: design/kdoc_pkg.sv
// shared types and constants of the keypad door opener controller
// no dependencies; imported by every module of the block
package kdoc_pkg;

  // key codes
  localparam logic [7:0] KEY_CLEAR    = 8'h2A;
  localparam logic [7:0] KEY_ENTER    = 8'h23;
  localparam logic [7:0] KEY_DIGIT_LO = 8'h30;
  localparam logic [7:0] KEY_DIGIT_HI = 8'h39;

  // door states
  localparam logic [1:0] ST_INIT       = 2'd0;
  localparam logic [1:0] ST_CLOSED     = 2'd1;
  localparam logic [1:0] ST_NOT_CLOSED = 2'd2;
  localparam logic [1:0] ST_HOLD_OPEN  = 2'd3;

  // code outcomes
  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_PASS = 2'd1;
  localparam logic [1:0] OUT_FAIL = 2'd2;

  // register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_CLOSE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELAY_HOLD  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CODE_FIRST  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CODE_SECOND = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CODE_THIRD  = 3'd5;

  // number of code registers that exist
  localparam int unsigned CodeRegs = 3;

  // register reset values
  localparam logic [31:0] RST_AUTO_CLOSE = 32'd240000;
  localparam logic [15:0] RST_RELAY_HOLD = 16'd500;
  localparam logic [15:0] RST_DEBOUNCE   = 16'd1000;
  localparam logic [31:0] RST_CODE       = 32'hFFFF_FFFF;

  // key event seen by the door state machine
  typedef struct packed {
    logic enter;
    logic passed;
  } key_evt_t;

  // timing registers seen by the door state machine
  typedef struct packed {
    logic [31:0] auto_close_ticks;
    logic [15:0] relay_hold_ticks;
  } door_cfg_t;

  // one result word
  typedef struct packed {
    logic       door_open;
    logic [1:0] code_outcome;
    logic       relay_drive;
    logic [1:0] state_change;
  } result_t;

endpackage

// File: design/kdoc_debounce.sv
// reed switch debouncer
// depends on kdoc_pkg
module kdoc_debounce
  import kdoc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        reed_level_i,
  input  logic [15:0] debounce_ticks_i,
  output logic        position_o
);

  logic        pos_q, pos_d;
  logic [15:0] cnt_q, cnt_d;

  // count ticks while the raw level differs from the position
  always_comb begin
    pos_d = pos_q;
    cnt_d = '0;
    if (reed_level_i != pos_q) begin
      cnt_d = cnt_q + 16'd1;
      if (cnt_q >= debounce_ticks_i) begin
        cnt_d = '0;
        pos_d = reed_level_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 1'b0;
      cnt_q <= '0;
    end else if (en_i) begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  assign position_o = pos_d;

endmodule

// File: design/kdoc_keypad.sv
// digit buffer and code compare of the keypad
// depends on kdoc_pkg
module kdoc_keypad
  import kdoc_pkg::*;
#(
  parameter int unsigned CODE_DIGITS = 4,
  parameter int unsigned CODE_COUNT  = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [7:0]                 key_code_i,
  input  logic [CodeRegs-1:0][31:0]  codes_i,
  output logic [1:0]                 outcome_o,
  output key_evt_t                   evt_o
);

  localparam int unsigned IdxW     = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int unsigned PackW    = 8 * CODE_DIGITS;
  localparam int unsigned NumCmp   = (CODE_COUNT > CodeRegs) ? CodeRegs : CODE_COUNT;
  localparam logic [IdxW:0] LastIdx = (IdxW + 1)'(CODE_DIGITS - 1);

  logic [CODE_DIGITS-1:0][7:0] buf_q, buf_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [IdxW:0]               idx_inc;
  logic [PackW-1:0]            packed_code;
  logic [NumCmp-1:0]           hit;
  logic                        is_digit;
  logic                        match;

  // first digit in the most significant byte
  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      packed_code[8*(CODE_DIGITS-1-i) +: 8] = buf_q[i];
    end
  end

  // compare against the code registers, zero extended above 32 bits
  for (genvar g = 0; g < NumCmp; g++) begin : g_cmp
    logic [PackW-1:0] code_ext;
    assign code_ext = PackW'({32'd0, codes_i[g]});
    assign hit[g]   = (code_ext == packed_code);
  end

  assign match    = |hit;
  assign is_digit = (key_code_i >= KEY_DIGIT_LO) && (key_code_i <= KEY_DIGIT_HI);
  assign idx_inc  = {1'b0, idx_q} + 1'b1;

  // buffer update and outcome
  always_comb begin
    buf_d     = buf_q;
    idx_d     = idx_q;
    outcome_o = OUT_NONE;
    if (is_digit) begin
      buf_d[idx_q] = key_code_i;
      idx_d = (idx_inc > LastIdx) ? LastIdx[IdxW-1:0] : idx_inc[IdxW-1:0];
    end else if (key_code_i == KEY_CLEAR) begin
      buf_d     = '0;
      idx_d     = '0;
      outcome_o = OUT_FAIL;
    end else if (key_code_i == KEY_ENTER) begin
      buf_d     = '0;
      idx_d     = '0;
      outcome_o = match ? OUT_PASS : OUT_FAIL;
    end
  end

  assign evt_o.enter  = (key_code_i == KEY_ENTER);
  assign evt_o.passed = (key_code_i == KEY_ENTER) && match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      idx_q <= '0;
    end else if (en_i) begin
      buf_q <= buf_d;
      idx_q <= idx_d;
    end
  end

endmodule

// File: design/kdoc_door_fsm.sv
// door state machine with relay pulse timer and auto-close timer
// depends on kdoc_pkg
module kdoc_door_fsm
  import kdoc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       down_i,
  input  key_evt_t   evt_i,
  input  door_cfg_t  cfg_i,
  output logic [1:0] state_change_o,
  output logic       relay_drive_o
);

  logic [1:0]  st_q, st_d;
  logic [15:0] rc_q, rc_d;
  logic        ron_q, ron_d;
  logic [31:0] ac_q, ac_d;
  logic        fire;

  always_comb begin
    // relay release check comes first
    rc_d  = rc_q + 16'd1;
    ron_d = ron_q;
    if (rc_q == cfg_i.relay_hold_ticks) begin
      rc_d  = '0;
      ron_d = 1'b0;
    end

    st_d = st_q;
    ac_d = ac_q;
    fire = 1'b0;
    unique case (st_q)
      ST_INIT: begin
        st_d = down_i ? ST_CLOSED : ST_NOT_CLOSED;
      end
      ST_CLOSED: begin
        fire = evt_i.passed;
        if (!down_i) begin
          st_d = ST_NOT_CLOSED;
          ac_d = '0;
        end
      end
      ST_NOT_CLOSED: begin
        if (evt_i.passed) begin
          st_d = ST_HOLD_OPEN;
        end else if (evt_i.enter) begin
          fire = 1'b1;
        end else begin
          ac_d = ac_q + 32'd1;
          if (ac_q == cfg_i.auto_close_ticks) begin
            ac_d = '0;
            fire = 1'b1;
          end
        end
        if (down_i) st_d = ST_CLOSED;
      end
      ST_HOLD_OPEN: begin
        if (!evt_i.passed && evt_i.enter) begin
          fire = 1'b1;
          st_d = ST_NOT_CLOSED;
          ac_d = '0;
        end
        if (down_i) st_d = ST_CLOSED;
      end
      default: st_d = ST_INIT;
    endcase

    // activation restarts the relay pulse
    if (fire) begin
      rc_d  = '0;
      ron_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_INIT;
      rc_q  <= RST_RELAY_HOLD;
      ron_q <= 1'b0;
      ac_q  <= '0;
    end else if (en_i) begin
      st_q  <= st_d;
      rc_q  <= rc_d;
      ron_q <= ron_d;
      ac_q  <= ac_d;
    end
  end

  assign state_change_o = (st_d != st_q) ? st_d : ST_INIT;
  assign relay_drive_o  = ron_d;

endmodule

// File: design/keypad_door_opener_controller.sv
// top level of the keypad door opener controller: ports, registers, pipeline
// depends on kdoc_pkg, kdoc_debounce, kdoc_keypad, kdoc_door_fsm, assert_macros.svh
//
// One input word is one tick: a key code and the raw reed level. Every word
// gives exactly one result word. The word waits in the input register until the
// output register has room; at that edge the debouncer, keypad buffer and door
// state machine update together and the result lands in the output register.
// A new word can be taken every cycle, so the block sustains one tick per
// clock; the only stall comes from the result side holding m_axis_tready low
// once both registers are full. Registers are written through the cfg port
// (index 0 auto close ticks, 1 relay hold ticks, 2 debounce ticks, 3 to 5 the
// codes, four ASCII digits with the first digit in the high byte);
// cfg_ready_o is always high, writes to other indexes are dropped, and writes
// are meant for idle time.
module keypad_door_opener_controller
  import kdoc_pkg::*;
#(
  parameter int unsigned CODE_DIGITS = 4,
  parameter int unsigned CODE_COUNT  = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [7:0] key_code, [8] reed_level, rest zero
  // result words
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [1:0] state_change, [2] relay_drive,
                                            // [4:3] code_outcome, [5] door_open
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  `include "assert_macros.svh"

  logic                      in_valid_q;
  logic [7:0]                key_q;
  logic                      reed_q;
  logic                      out_valid_q;
  result_t                   out_q, out_d;
  logic                      adv;
  logic                      cfg_we;

  logic [31:0]               auto_close_q;
  logic [15:0]               relay_hold_q;
  logic [15:0]               debounce_q;
  logic [CodeRegs-1:0][31:0] codes_q;
  door_cfg_t                 door_cfg;

  logic                      position;
  key_evt_t                  key_evt;

  // register file
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_close_q <= RST_AUTO_CLOSE;
      relay_hold_q <= RST_RELAY_HOLD;
      debounce_q   <= RST_DEBOUNCE;
      codes_q      <= {CodeRegs{RST_CODE}};
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_AUTO_CLOSE:  auto_close_q <= cfg_data_i;
        CFG_RELAY_HOLD:  relay_hold_q <= cfg_data_i[15:0];
        CFG_DEBOUNCE:    debounce_q   <= cfg_data_i[15:0];
        CFG_CODE_FIRST:  codes_q[0]   <= cfg_data_i;
        CFG_CODE_SECOND: codes_q[1]   <= cfg_data_i;
        CFG_CODE_THIRD:  codes_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign door_cfg.auto_close_ticks = auto_close_q;
  assign door_cfg.relay_hold_ticks = relay_hold_q;

  // pipeline handshake
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      key_q  <= s_axis_tdata[7:0];
      reed_q <= s_axis_tdata[8];
    end
  end

  kdoc_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (adv),
    .reed_level_i     (reed_q),
    .debounce_ticks_i (debounce_q),
    .position_o       (position)
  );

  kdoc_keypad #(
    .CODE_DIGITS (CODE_DIGITS),
    .CODE_COUNT  (CODE_COUNT)
  ) u_keypad (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .key_code_i (key_q),
    .codes_i    (codes_q),
    .outcome_o  (out_d.code_outcome),
    .evt_o      (key_evt)
  );

  kdoc_door_fsm u_door_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .down_i         (!position),
    .evt_i          (key_evt),
    .cfg_i          (door_cfg),
    .state_change_o (out_d.state_change),
    .relay_drive_o  (out_d.relay_drive)
  );

  assign out_d.door_open = position;

  // result word register
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  // a word moving on always lands in the result register
  `KDOC_ASSERT(a_adv_fills_out, clk_i, rst_ni, adv |=> out_valid_q)
  // input side stalls only when both registers hold words
  `KDOC_ASSERT(a_stall_when_full, clk_i, rst_ni,
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
  // an outcome code outside the defined set never leaves the block
  `KDOC_NEVER(a_no_bad_outcome, clk_i, rst_ni,
    out_valid_q && (out_q.code_outcome != OUT_NONE) &&
    (out_q.code_outcome != OUT_PASS) && (out_q.code_outcome != OUT_FAIL))
  // a code event only ever follows a clear or enter key
  `KDOC_ASSERT(a_outcome_from_key, clk_i, rst_ni,
    (adv && (key_q != KEY_CLEAR) && (key_q != KEY_ENTER)) |=>
    (out_q.code_outcome == OUT_NONE))

endmodule

// File: tb/tb_keypad_door_opener_controller.sv
// self-checking testbench of the keypad door opener controller
// depends on kdoc_pkg and keypad_door_opener_controller; a directed table, then random phases
// every result word is checked field by field, against a fixed table entry or a tick-level predictor
module tb_keypad_door_opener_controller;
  import kdoc_pkg::*;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 128;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DIR_ROWS    = 34;

  // no state change reported for this tick
  localparam logic [1:0] NO_CHANGE = 2'd0;
  // indexes that map to no register
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 3'd7;

  // results that can be read straight off the reset settings
  localparam result_t R_FIRST = '{door_open: 1'b0, code_outcome: OUT_NONE,
                                  relay_drive: 1'b0, state_change: ST_CLOSED};
  localparam result_t R_QUIET = '{door_open: 1'b0, code_outcome: OUT_NONE,
                                  relay_drive: 1'b0, state_change: NO_CHANGE};
  localparam result_t R_REJECT = '{door_open: 1'b0, code_outcome: OUT_FAIL,
                                   relay_drive: 1'b0, state_change: NO_CHANGE};

  // one row of the directed table: a register write or an input word
  typedef struct packed {
    logic               is_reg;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        val;
    logic [7:0]         key;
    logic               reed;
    logic               typed;   // res holds the expected word
    result_t            res;
  } step_t;

  typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata  = '0;  // [7:0] key_code, [8] reed_level
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;        // [1:0] state_change, [2] relay_drive,
                                           // [4:3] code_outcome, [5] door_open
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [31:0]        cfg_data_i    = '0;

  keypad_door_opener_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor copy of the registers
  logic [31:0] close_lim;
  logic [15:0] hold_lim;
  logic [15:0] bounce_lim;
  logic [31:0] code_reg [CodeRegs];

  // predictor copy of the block state
  logic [1:0]  door_st;
  logic        door_pos;
  logic [15:0] bounce_cnt;
  logic [15:0] hold_cnt;
  logic        relay_q;
  logic [31:0] close_cnt;
  logic [7:0]  digit_buf [4];
  int unsigned digit_idx;

  result_t     due_results [$];
  logic [7:0]  key_script [$];
  step_t       dir_tbl [DIR_ROWS];
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  // receiver stall pattern
  rx_mode_e    rx_mode   = RX_FREE;
  int unsigned rx_tick   = 0;
  int unsigned rx_period = 2;
  int unsigned rx_run    = 0;
  logic        rx_hold   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // advance the predictor by one tick and return the word it gives
  function automatic result_t door_step(input logic [7:0] key, input logic raw);
    logic [1:0]  outcome;
    logic [1:0]  prev;
    logic        down;
    logic        passed;
    logic        enter;
    logic [31:0] entered;
    result_t     r;
    int          i;
    // reed debounce
    if (raw != door_pos) begin
      if (bounce_cnt >= bounce_lim) begin
        bounce_cnt = '0;
        door_pos   = raw;
      end else begin
        bounce_cnt = bounce_cnt + 16'd1;
      end
    end else begin
      bounce_cnt = '0;
    end
    down  = !door_pos;
    enter = (key == KEY_ENTER);
    // keypad buffer, a full buffer keeps overwriting the last slot
    outcome = OUT_NONE;
    if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
      digit_buf[digit_idx] = key;
      if (digit_idx < 3) digit_idx++;
    end else if (key == KEY_CLEAR || enter) begin
      outcome = OUT_FAIL;
      if (enter) begin
        entered = {digit_buf[0], digit_buf[1], digit_buf[2], digit_buf[3]};
        for (i = 0; i < CodeRegs; i++) begin
          if (code_reg[i] == entered) outcome = OUT_PASS;
        end
      end
      digit_buf = '{default: 8'h00};
      digit_idx = 0;
    end
    passed = (outcome == OUT_PASS);
    // relay release comes before the state machine
    if (hold_cnt == hold_lim) begin
      hold_cnt = '0;
      relay_q  = 1'b0;
    end else begin
      hold_cnt = hold_cnt + 16'd1;
    end
    // door state machine, door down always wins
    prev = door_st;
    case (door_st)
      ST_INIT: door_st = down ? ST_CLOSED : ST_NOT_CLOSED;
      ST_CLOSED: begin
        if (passed) begin
          hold_cnt = '0;
          relay_q  = 1'b1;
        end
        if (!down) begin
          door_st   = ST_NOT_CLOSED;
          close_cnt = '0;
        end
      end
      ST_NOT_CLOSED: begin
        if (passed) begin
          door_st = ST_HOLD_OPEN;
        end else if (enter) begin
          hold_cnt = '0;
          relay_q  = 1'b1;
        end else if (close_cnt == close_lim) begin
          close_cnt = '0;
          hold_cnt  = '0;
          relay_q   = 1'b1;
        end else begin
          close_cnt = close_cnt + 32'd1;
        end
        if (down) door_st = ST_CLOSED;
      end
      default: begin
        if (!passed && enter) begin
          hold_cnt  = '0;
          relay_q   = 1'b1;
          door_st   = ST_NOT_CLOSED;
          close_cnt = '0;
        end
        if (down) door_st = ST_CLOSED;
      end
    endcase
    r.state_change = (door_st != prev) ? door_st : NO_CHANGE;
    r.relay_drive  = relay_q;
    r.code_outcome = outcome;
    r.door_open    = door_pos;
    return r;
  endfunction

  // register write as seen by the predictor, values cut to register width
  function automatic void reg_update(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    case (idx)
      CFG_AUTO_CLOSE:  close_lim   = val;
      CFG_RELAY_HOLD:  hold_lim    = val[15:0];
      CFG_DEBOUNCE:    bounce_lim  = val[15:0];
      CFG_CODE_FIRST:  code_reg[0] = val;
      CFG_CODE_SECOND: code_reg[1] = val;
      CFG_CODE_THIRD:  code_reg[2] = val;
      default: ;
    endcase
  endfunction

  // four random ascii digits, first digit in the high byte
  function automatic logic [31:0] digit_code();
    logic [31:0] c;
    int          k;
    c = '0;
    for (k = 0; k < 4; k++) c = {c[23:0], 8'(KEY_DIGIT_LO + $urandom_range(0, 9))};
    return c;
  endfunction

  function automatic step_t word_row(input logic [7:0] key, input logic reed);
    return '{is_reg: 1'b0, idx: '0, val: '0, key: key, reed: reed, typed: 1'b0,
             res: R_QUIET};
  endfunction

  function automatic step_t fixed_row(input logic [7:0] key, input logic reed,
                                      input result_t res);
    return '{is_reg: 1'b0, idx: '0, val: '0, key: key, reed: reed, typed: 1'b1,
             res: res};
  endfunction

  function automatic step_t reg_row(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    return '{is_reg: 1'b1, idx: idx, val: val, key: '0, reed: 1'b0, typed: 1'b0,
             res: R_QUIET};
  endfunction

  // offer one word, hold it until taken, then log its expected result
  task automatic send_word(input logic [7:0] key, input logic reed, input logic typed,
                           input result_t fixed_res);
    result_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, reed, key};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = door_step(key, reed);
    due_results.push_back(typed ? fixed_res : pred);
  endtask

  // register write, valid stays high for the next write of a batch
  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_update(idx, val);
  endtask

  // stop sending until every expected word is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  // stimulus
  initial begin : stim
    logic        in_batch;
    logic        reed_lvl;
    logic [31:0] close_v;
    logic [31:0] code_a;
    logic [15:0] hold_v;
    logic [15:0] bounce_v;
    int          ph;
    int          w;
    int          r;
    int          k;
    int          n;
    int          src;
    int          pick;
    int          gap;
    int          burst_left;

    // predictor reset state
    close_lim  = RST_AUTO_CLOSE;
    hold_lim   = RST_RELAY_HOLD;
    bounce_lim = RST_DEBOUNCE;
    code_reg   = '{default: RST_CODE};
    door_st    = ST_INIT;
    door_pos   = 1'b0;
    bounce_cnt = '0;
    hold_cnt   = RST_RELAY_HOLD;
    relay_q    = 1'b0;
    close_cnt  = '0;
    digit_buf  = '{default: 8'h00};
    digit_idx  = 0;

    dir_tbl = '{
      // reset settings: door stays down, codes never match
      fixed_row(8'h00, 1'b0, R_FIRST),
      fixed_row(8'hFF, 1'b1, R_QUIET),
      fixed_row(8'h31, 1'b0, R_QUIET),           // '1'
      fixed_row(8'h32, 1'b0, R_QUIET),
      fixed_row(8'h33, 1'b0, R_QUIET),
      fixed_row(8'h34, 1'b0, R_QUIET),
      fixed_row(KEY_DIGIT_HI, 1'b0, R_QUIET),    // overwrites the last slot
      fixed_row(KEY_ENTER, 1'b0, R_REJECT),      // rejected while closed
      fixed_row(KEY_DIGIT_LO, 1'b1, R_QUIET),
      fixed_row(8'h2F, 1'b0, R_QUIET),           // just below the digits
      fixed_row(8'h3A, 1'b1, R_QUIET),           // just above the digits
      fixed_row(KEY_CLEAR, 1'b0, R_REJECT),
      // short timing, codes 1234, 9999 and zero, spare indexes ignored
      reg_row(CFG_RELAY_HOLD, 32'h0000_0002),
      reg_row(CFG_DEBOUNCE, 32'h0000_0000),
      reg_row(CFG_AUTO_CLOSE, 32'h0000_0001),
      reg_row(CFG_CODE_FIRST, 32'h3132_3334),
      reg_row(CFG_CODE_SECOND, 32'h3939_3939),
      reg_row(CFG_CODE_THIRD, 32'h0000_0000),
      reg_row(CFG_SPARE_A, 32'h3535_3535),
      reg_row(CFG_SPARE_B, 32'h3535_3535),
      // good code while closed pulses the relay
      word_row(8'h31, 1'b0),
      word_row(8'h32, 1'b0),
      word_row(8'h33, 1'b0),
      word_row(8'h34, 1'b0),
      word_row(KEY_ENTER, 1'b0),
      // door lifts, auto close fires
      word_row(8'h00, 1'b1),
      word_row(8'h00, 1'b1),
      word_row(8'h00, 1'b1),
      // bad code while not closed pulses the relay
      word_row(8'h35, 1'b1),
      word_row(KEY_ENTER, 1'b1),
      // empty buffer matches the zero code: hold open
      word_row(KEY_ENTER, 1'b1),
      // bad code in hold open goes back to not closed
      word_row(8'h37, 1'b1),
      word_row(KEY_ENTER, 1'b1),
      // door down wins
      word_row(8'h00, 1'b0)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    in_batch = 1'b0;
    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_tbl[r].is_reg) begin
        if (!in_batch) drain();
        in_batch = 1'b1;
        reg_write(dir_tbl[r].idx, dir_tbl[r].val);
      end else begin
        if (in_batch) cfg_valid_i <= 1'b0;
        in_batch = 1'b0;
        send_word(dir_tbl[r].key, dir_tbl[r].reed, dir_tbl[r].typed, dir_tbl[r].res);
      end
    end

    // random phases, each under its own register settings
    reed_lvl   = 1'b0;
    burst_left = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          close_v  = '0;
          hold_v   = '0;
          bounce_v = '0;
          code_a   = '0;
        end
        1: begin
          close_v  = '1;
          hold_v   = '1;
          bounce_v = '1;
          code_a   = '1;
        end
        default: begin
          close_v  = $urandom_range(0, 40);
          hold_v   = 16'($urandom_range(0, 12));
          bounce_v = 16'($urandom_range(0, 6));
          code_a   = ($urandom_range(0, 3) == 0) ? $urandom() : digit_code();
        end
      endcase
      drain();
      reg_write(CFG_AUTO_CLOSE, close_v);
      reg_write(CFG_RELAY_HOLD, {16'($urandom()), hold_v});
      reg_write(CFG_DEBOUNCE, {16'($urandom()), bounce_v});
      reg_write(CFG_CODE_FIRST, code_a);
      reg_write(CFG_CODE_SECOND, digit_code());
      reg_write(CFG_CODE_THIRD, digit_code());
      reg_write((ph % 2 == 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
      cfg_valid_i <= 1'b0;

      for (w = 0; w < PHASE_WORDS; w++) begin
        // let the pipeline run dry once per phase
        if (w == PHASE_WORDS / 2) drain();
        // bursts and gaps, none in every third phase
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = (ph % 3 == 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        burst_left--;
        // refill the key script: code entries nearly half the time, the rest noise
        if (key_script.size() == 0) begin
          pick = $urandom_range(0, 19);
          if (pick < 9) begin
            src = $urandom_range(0, CodeRegs);
            n   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : 4;
            for (k = 0; k < n; k++) begin
              if (src < CodeRegs && k < 4) key_script.push_back(code_reg[src][31 - 8*k -: 8]);
              else key_script.push_back(8'(KEY_DIGIT_LO + $urandom_range(0, 9)));
              if ($urandom_range(0, 2) == 0) key_script.push_back(8'h00);
            end
            key_script.push_back(KEY_ENTER);
          end else if (pick < 11) begin
            key_script.push_back(KEY_CLEAR);
          end else if (pick < 13) begin
            key_script.push_back(KEY_ENTER);
          end else if (pick < 16) begin
            key_script.push_back(8'($urandom_range(0, 255)));
          end else begin
            repeat ($urandom_range(1, 6)) key_script.push_back(8'h00);
          end
        end
        // door moves now and then, with single-tick glitches
        if ($urandom_range(0, 39) == 0) reed_lvl = !reed_lvl;
        send_word(key_script.pop_front(), reed_lvl ^ ($urandom_range(0, 29) == 0), 1'b0,
                  R_QUIET);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver ready, following a randomly chosen stall pattern
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_tick % 256 == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      rx_period = $urandom_range(2, 5);
    end
    case (rx_mode)
      RX_FREE:     m_axis_tready <= 1'b1;
      RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: m_axis_tready <= (rx_tick % rx_period == 0);
      default: begin
        if (rx_run == 0) begin
          rx_hold = !rx_hold;
          rx_run  = rx_hold ? $urandom_range(1, 10) : $urandom_range(1, 20);
        end
        rx_run--;
        m_axis_tready <= rx_hold;
      end
    endcase
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[5:0]);
      if (due_results.size() == 0) begin
        $error("result word %h with nothing expected", m_axis_tdata);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        if (got.state_change !== want.state_change) begin
          $error("state_change: expected %0d, got %0d", want.state_change, got.state_change);
          err_cnt++;
        end
        if (got.relay_drive !== want.relay_drive) begin
          $error("relay_drive: expected %0d, got %0d", want.relay_drive, got.relay_drive);
          err_cnt++;
        end
        if (got.code_outcome !== want.code_outcome) begin
          $error("code_outcome: expected %0d, got %0d", want.code_outcome, got.code_outcome);
          err_cnt++;
        end
        if (got.door_open !== want.door_open) begin
          $error("door_open: expected %0d, got %0d", want.door_open, got.door_open);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// File: files.f
+incdir+design
design/kdoc_pkg.sv
design/kdoc_debounce.sv
design/kdoc_keypad.sv
design/kdoc_door_fsm.sv
design/keypad_door_opener_controller.sv
tb/tb_keypad_door_opener_controller.sv
